FILE: rtl/ilist_pkg.sv
`default_nettype none

package ilist_pkg;

  localparam int DEPTH      = 16;
  localparam int ELEM_WIDTH = 32;

  localparam int OP_W   = 3;
  localparam int POS_W  = 5;
  localparam int WORD_W = 32;
  localparam int ST_W   = 2;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  typedef enum logic [OP_W-1:0] {
    OP_GET      = 3'd0,
    OP_SET      = 3'd1,
    OP_APPEND   = 3'd2,
    OP_INSERT   = 3'd3,
    OP_REMOVE   = 3'd4,
    OP_POP      = 3'd5,
    OP_CLEAR    = 3'd6,
    OP_CONTAINS = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LOWER,
    CELL_FROM_UPPER
  } cell_op_t;

endpackage

`default_nettype wire

FILE: rtl/indexed_list_engine_top.sv
// channel | ports                                                 | direction
// --------+-------------------------------------------------------+----------
// request | in_valid in_stall in_operation in_position in_word_in | in
// result  | out_valid out_stall out_word_out out_found            | out
//         | out_entry_count out_status                            |
//
// one request per cycle while in_stall is low; its result is registered and shows the next cycle
// every command completes through the shifting row of entry cells
// in_stall is high only while a result is held and out_stall is high
// reset clears the entry count and the result valid flag, entry words are kept
`default_nettype none

module indexed_list_engine_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ilist_pkg::OP_W-1:0]    in_operation,
  input  wire logic [ilist_pkg::POS_W-1:0]   in_position,
  input  wire logic [ilist_pkg::WORD_W-1:0]  in_word_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ilist_pkg::WORD_W-1:0]       out_word_out,
  output logic                               out_found,
  output logic [ilist_pkg::POS_W-1:0]        out_entry_count,
  output logic [ilist_pkg::ST_W-1:0]         out_status
);

  localparam int DEPTH = ilist_pkg::DEPTH;
  localparam int CNT_W = ilist_pkg::CNT_W;
  localparam int CMP_W = ilist_pkg::CMP_W;
  localparam int IDX_W = ilist_pkg::IDX_W;

  logic                   in_fire;
  ilist_pkg::op_t         op;
  ilist_pkg::elem_t       word;
  logic [CMP_W-1:0]       pos_w;
  logic [CMP_W-1:0]       fill_w;
  logic [CMP_W-1:0]       rd_sel;
  ilist_pkg::elem_t       rd_word;

  logic [CNT_W-1:0]       fill_r;
  logic [CNT_W-1:0]       fill_nxt;
  logic                   full;

  logic                   do_set;
  logic                   do_append;
  logic                   do_insert;
  logic                   do_remove;

  ilist_pkg::cell_op_t    cell_op [DEPTH];
  ilist_pkg::elem_t       cell_q  [DEPTH];
  logic [DEPTH-1:0]       cell_match;
  logic [DEPTH-1:0]       hit_v;

  ilist_pkg::status_t     status;
  ilist_pkg::elem_t       word_o;
  logic                   found_o;

  logic                                out_valid_r;
  logic                                out_valid_nxt;
  logic [ilist_pkg::WORD_W-1:0]        out_word_r;
  logic                                out_found_r;
  logic [ilist_pkg::POS_W-1:0]         out_count_r;
  ilist_pkg::status_t                  out_status_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  assign op     = ilist_pkg::op_t'(in_operation);
  assign word   = ilist_pkg::ELEM_WIDTH'(in_word_in);
  assign pos_w  = CMP_W'(in_position);
  assign fill_w = CMP_W'(fill_r);
  assign full   = (fill_r == CNT_W'(DEPTH));

  // pop reads the last entry, get and remove read at the position
  assign rd_sel  = (op == ilist_pkg::OP_POP) ? (fill_w - 1'b1) : pos_w;
  assign rd_word = cell_q[rd_sel[IDX_W-1:0]];

  always_comb begin
    status    = ilist_pkg::ST_OK;
    word_o    = '0;
    found_o   = 1'b0;
    fill_nxt  = fill_r;
    do_set    = 1'b0;
    do_append = 1'b0;
    do_insert = 1'b0;
    do_remove = 1'b0;
    case (op)
      ilist_pkg::OP_GET: begin
        if (pos_w >= fill_w) status = ilist_pkg::ST_RANGE;
        else word_o = rd_word;
      end
      ilist_pkg::OP_SET: begin
        if (pos_w >= fill_w) status = ilist_pkg::ST_RANGE;
        else do_set = 1'b1;
      end
      ilist_pkg::OP_APPEND: begin
        if (full) begin
          status = ilist_pkg::ST_FULL;
        end else begin
          do_append = 1'b1;
          fill_nxt  = fill_r + 1'b1;
        end
      end
      ilist_pkg::OP_INSERT: begin
        if (pos_w > fill_w) begin
          status = ilist_pkg::ST_RANGE;
        end else if (full) begin
          status = ilist_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
          fill_nxt  = fill_r + 1'b1;
        end
      end
      ilist_pkg::OP_REMOVE: begin
        if (pos_w >= fill_w) begin
          status = ilist_pkg::ST_RANGE;
        end else begin
          word_o    = rd_word;
          do_remove = 1'b1;
          fill_nxt  = fill_r - 1'b1;
        end
      end
      ilist_pkg::OP_POP: begin
        if (fill_r == '0) begin
          status = ilist_pkg::ST_EMPTY;
        end else begin
          word_o   = rd_word;
          fill_nxt = fill_r - 1'b1;
        end
      end
      ilist_pkg::OP_CLEAR: begin
        fill_nxt = '0;
      end
      ilist_pkg::OP_CONTAINS: begin
        found_o = |hit_v;
      end
      default: begin
        status = ilist_pkg::ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX      = CMP_W'(i);
    localparam logic [CMP_W-1:0] IDX_NEXT = CMP_W'(i + 1);

    ilist_pkg::elem_t lower_d;
    ilist_pkg::elem_t upper_d;

    if (i == 0) begin : g_first
      assign lower_d = '0;
    end else begin : g_mid_lo
      assign lower_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper_d = '0;
    end else begin : g_mid_hi
      assign upper_d = cell_q[i+1];
    end

    always_comb begin
      cell_op[i] = ilist_pkg::CELL_HOLD;
      if (in_fire) begin
        if ((do_set && pos_w == IDX) || (do_append && fill_w == IDX) ||
            (do_insert && pos_w == IDX)) begin
          cell_op[i] = ilist_pkg::CELL_LOAD;
        end else if (do_insert && IDX > pos_w && IDX <= fill_w) begin
          cell_op[i] = ilist_pkg::CELL_FROM_LOWER;
        end else if (do_remove && IDX >= pos_w && IDX_NEXT < fill_w) begin
          cell_op[i] = ilist_pkg::CELL_FROM_UPPER;
        end
      end
    end

    ilist_cell u_cell (
      .clk     (clk),
      .op      (cell_op[i]),
      .word    (word),
      .lower_q (lower_d),
      .upper_q (upper_d),
      .q       (cell_q[i]),
      .match   (cell_match[i])
    );

    assign hit_v[i] = cell_match[i] && (IDX < fill_w);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word_r   <= ilist_pkg::WORD_W'(word_o);
      out_found_r  <= found_o;
      out_count_r  <= ilist_pkg::POS_W'(fill_nxt);
      out_status_r <= status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word_out    = out_word_r;
  assign out_found       = out_found_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

endmodule

`default_nettype wire

FILE: rtl/ilist_cell.sv
`default_nettype none

module ilist_cell (
  input  wire logic              clk,
  input  wire ilist_pkg::cell_op_t op,
  input  wire ilist_pkg::elem_t  word,
  input  wire ilist_pkg::elem_t  lower_q,
  input  wire ilist_pkg::elem_t  upper_q,
  output ilist_pkg::elem_t       q,
  output logic                   match
);

  ilist_pkg::elem_t data_r;
  ilist_pkg::elem_t data_nxt;

  always_comb begin
    case (op)
      ilist_pkg::CELL_LOAD:       data_nxt = word;
      ilist_pkg::CELL_FROM_LOWER: data_nxt = lower_q;
      ilist_pkg::CELL_FROM_UPPER: data_nxt = upper_q;
      default:                    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q     = data_r;
  assign match = (data_r == word);

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH  = ilist_pkg::DEPTH;
  localparam int OP_W   = ilist_pkg::OP_W;
  localparam int POS_W  = ilist_pkg::POS_W;
  localparam int WORD_W = ilist_pkg::WORD_W;
  localparam int ST_W   = ilist_pkg::ST_W;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic               found;
    logic [POS_W-1:0]   count;
    ilist_pkg::status_t status;
  } list_result_t;

  localparam int QUIET_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_operation = ilist_pkg::OP_GET;
  logic [POS_W-1:0]     in_position = '0;
  logic [WORD_W-1:0]    in_word_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_W-1:0]    out_word_out;
  logic                 out_found;
  logic [POS_W-1:0]     out_entry_count;
  logic [ST_W-1:0]      out_status;

  // shadow copy of the list
  ilist_pkg::elem_t     list_words [DEPTH];
  int                   list_len = 0;
  list_result_t         expected_list_results [$];
  int                   mismatch_count = 0;
  int                   quiet_cycles = 0;
  bit                   sender_idles = 1'b1;
  bit                   receiver_idles = 1'b1;

  indexed_list_engine_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_word_in      (in_word_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_out    (out_word_out),
    .out_found       (out_found),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic list_result_t apply_list_command(ilist_pkg::op_t op,
                                                      logic [POS_W-1:0] pos,
                                                      logic [WORD_W-1:0] word);
    list_result_t     r;
    int               p;
    int               i;
    ilist_pkg::elem_t w;
    r.word   = '0;
    r.found  = 1'b0;
    r.status = ilist_pkg::ST_OK;
    p = int'(pos);
    w = ilist_pkg::elem_t'(word);
    case (op)
      ilist_pkg::OP_GET: begin
        if (p >= list_len) r.status = ilist_pkg::ST_RANGE;
        else r.word = WORD_W'(list_words[p]);
      end
      ilist_pkg::OP_SET: begin
        if (p >= list_len) r.status = ilist_pkg::ST_RANGE;
        else list_words[p] = w;
      end
      ilist_pkg::OP_APPEND: begin
        if (list_len >= DEPTH) begin
          r.status = ilist_pkg::ST_FULL;
        end else begin
          list_words[list_len] = w;
          list_len++;
        end
      end
      ilist_pkg::OP_INSERT: begin
        if (p > list_len) begin
          r.status = ilist_pkg::ST_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = ilist_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = w;
          list_len++;
        end
      end
      ilist_pkg::OP_REMOVE, ilist_pkg::OP_POP: begin
        if (op == ilist_pkg::OP_POP && list_len == 0) begin
          r.status = ilist_pkg::ST_EMPTY;
        end else if (op == ilist_pkg::OP_REMOVE && p >= list_len) begin
          r.status = ilist_pkg::ST_RANGE;
        end else begin
          if (op == ilist_pkg::OP_POP) p = list_len - 1;
          r.word = WORD_W'(list_words[p]);
          for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      ilist_pkg::OP_CLEAR: list_len = 0;
      default: begin
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] == w) r.found = 1'b1;
        end
      end
    endcase
    r.count = POS_W'(list_len);
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return WORD_W'(1) << $urandom_range(WORD_W - 1);
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic send_request(ilist_pkg::op_t op, logic [POS_W-1:0] pos,
                              logic [WORD_W-1:0] word);
    while (sender_idles && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_word_in   <= word;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_list_results.push_back(apply_list_command(op, pos, word));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_list_results.size() != 0);
  endtask

  task automatic random_commands(int count, int grow_pct);
    ilist_pkg::op_t    op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    int                roll;
    int                grow_w;
    int                shrink_w;
    grow_w   = grow_pct / 2;
    shrink_w = (100 - grow_pct) / 2;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        op = ilist_pkg::OP_CLEAR;
      end else if (roll < 2 + grow_w) begin
        op = $urandom_range(1) ? ilist_pkg::OP_APPEND : ilist_pkg::OP_INSERT;
      end else if (roll < 2 + grow_w + shrink_w) begin
        op = $urandom_range(1) ? ilist_pkg::OP_REMOVE : ilist_pkg::OP_POP;
      end else begin
        case ($urandom_range(2))
          0: op = ilist_pkg::OP_GET;
          1: op = ilist_pkg::OP_SET;
          default: op = ilist_pkg::OP_CONTAINS;
        endcase
      end
      if ($urandom_range(9) == 0) pos = POS_W'($urandom_range(31));
      else if (op == ilist_pkg::OP_INSERT) pos = POS_W'($urandom_range(list_len));
      else if (list_len > 0) pos = POS_W'($urandom_range(list_len - 1));
      else pos = '0;
      if (op == ilist_pkg::OP_CONTAINS && list_len > 0 && $urandom_range(1))
        word = WORD_W'(list_words[$urandom_range(list_len - 1)]);
      else
        word = random_word();
      send_request(op, pos, word);
    end
  endtask

  task automatic test_empty_list();
    send_request(ilist_pkg::OP_GET, 5'd0, '0);
    send_request(ilist_pkg::OP_REMOVE, 5'd31, '0);
    send_request(ilist_pkg::OP_POP, 5'd0, '0);
    send_request(ilist_pkg::OP_CONTAINS, 5'd0, '1);
    send_request(ilist_pkg::OP_INSERT, 5'd1, 32'h0000_00ff);
  endtask

  task automatic test_fill_to_capacity();
    // insert at the end acts as append
    send_request(ilist_pkg::OP_INSERT, 5'd0, '0);
    send_request(ilist_pkg::OP_APPEND, 5'd0, '1);
    send_request(ilist_pkg::OP_INSERT, 5'd1, 32'h8000_0000);
    repeat (DEPTH - 3)
      send_request(ilist_pkg::OP_APPEND, POS_W'($urandom_range(31)), random_word());
    send_request(ilist_pkg::OP_APPEND, 5'd0, 32'h1234_5678);
    // bad position is reported ahead of full
    send_request(ilist_pkg::OP_INSERT, 5'd20, 32'h1234_5678);
    send_request(ilist_pkg::OP_INSERT, 5'd5, 32'h1234_5678);
  endtask

  task automatic test_access_and_shift();
    send_request(ilist_pkg::OP_SET, 5'd15, 32'h7fff_ffff);
    send_request(ilist_pkg::OP_GET, 5'd15, '0);
    send_request(ilist_pkg::OP_REMOVE, 5'd0, '0);
    send_request(ilist_pkg::OP_POP, 5'd0, '0);
    send_request(ilist_pkg::OP_CONTAINS, 5'd0, 32'h8000_0000);
  endtask

  task automatic test_clear();
    send_request(ilist_pkg::OP_CLEAR, 5'd16, '1);
    send_request(ilist_pkg::OP_CONTAINS, 5'd0, '0);
  endtask

  task automatic test_random_mixed();
    random_commands(450, 50);
    drain_results();
  endtask

  task automatic test_random_near_full();
    random_commands(350, 75);
    drain_results();
  endtask

  task automatic test_random_near_empty();
    random_commands(350, 25);
    drain_results();
  endtask

  task automatic test_back_to_back();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    random_commands(250, 55);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  always @(posedge clk) begin
    out_stall <= receiver_idles && ($urandom_range(99) < 24);
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_list_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: word=%h found=%b count=%0d status=%0d",
                   out_word_out, out_found, out_entry_count, out_status);
      end else begin
        want = expected_list_results.pop_front();
        if (out_word_out !== want.word || out_found !== want.found ||
            out_entry_count !== want.count || out_status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected word=%h found=%b count=%0d status=%0d",
                     want.word, want.found, want.count, want.status);
            $display("          got      word=%h found=%b count=%0d status=%0d",
                     out_word_out, out_found, out_entry_count, out_status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_fill_to_capacity();
    test_access_and_shift();
    test_clear();
    drain_results();
    test_random_mixed();
    test_random_near_full();
    test_back_to_back();
    test_random_near_empty();
    drain_results();
    repeat (8) @(posedge clk);
    if (expected_list_results.size() != 0) begin
      mismatch_count += expected_list_results.size();
    end
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
